### hdl/bis_pkg.sv
// shared types and constants for the bilinear image sampler
package bis_pkg;

  localparam int unsigned COORD_W   = 18;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
  localparam logic [OUT_W-1:0]  OUT_MAX    = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd1;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // parity of the clamped corner indices, selects the bank of each corner
  typedef struct packed {
    logic x0_odd;
    logic x1_odd;
    logic y0_odd;
    logic y1_odd;
  } corner_sel_t;

endpackage

### hdl/bis_addr_gen.sv
// edge clamping and bank address generation for pixel writes and sample reads
module bis_addr_gen #(
  parameter int unsigned MAX_COLS  = 256,
  parameter int unsigned MAX_ROWS  = 256,
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned CW        = 8,
  parameter int unsigned RW        = 8,
  parameter int unsigned CHW       = 7,
  parameter int unsigned RHW       = 7
) (
  input  logic                                xfer_i,
  input  logic                                operation_i,
  input  logic [7:0]                          write_col_i,
  input  logic [7:0]                          write_row_i,
  input  logic signed [bis_pkg::COORD_W-1:0]  sample_x_i,
  input  logic signed [bis_pkg::COORD_W-1:0]  sample_y_i,
  input  logic [bis_pkg::SIZE_W-1:0]          image_cols_i,
  input  logic [bis_pkg::SIZE_W-1:0]          image_rows_i,
  output logic                                wr_en_o,
  output logic [1:0]                          wr_bank_o,
  output logic [RHW+CHW-1:0]                  wr_addr_o,
  output logic                                rd_en_o,
  output logic [3:0][RHW+CHW-1:0]             rd_addr_o,
  output bis_pkg::corner_sel_t                rd_sel_o
);

  localparam int unsigned CSW  = $clog2(MAX_COLS + 1);
  localparam int unsigned RSW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned ECW  = (CSW > bis_pkg::SIZE_W) ? CSW : bis_pkg::SIZE_W;
  localparam int unsigned ERW  = (RSW > bis_pkg::SIZE_W) ? RSW : bis_pkg::SIZE_W;
  localparam int unsigned MXW  = (CW > RW) ? CW : RW;
  localparam int unsigned CMPW = ((bis_pkg::COORD_W > MXW) ? bis_pkg::COORD_W : MXW) + 2;

  logic [ECW-1:0] cols_ext, eff_cols;
  logic [ERW-1:0] rows_ext, eff_rows;
  logic [CW-1:0]  last_col;
  logic [RW-1:0]  last_row;

  logic signed [CMPW-1:0] ix0, ix1, iy0, iy1;
  logic signed [CMPW-1:0] lastc_s, lastr_s;
  logic [CW-1:0] x0, x1;
  logic [RW-1:0] y0, y1;
  logic [1:0][CHW-1:0] col_half;
  logic [1:0][RHW-1:0] row_half;
  logic [CW-1:0] wcol;
  logic [RW-1:0] wrow;

  assign cols_ext = ECW'(image_cols_i);
  assign rows_ext = ERW'(image_rows_i);

  always_comb begin
    if (cols_ext == '0) begin
      eff_cols = ECW'(1);
    end else if (cols_ext > ECW'(MAX_COLS)) begin
      eff_cols = ECW'(MAX_COLS);
    end else begin
      eff_cols = cols_ext;
    end
    if (rows_ext == '0) begin
      eff_rows = ERW'(1);
    end else if (rows_ext > ERW'(MAX_ROWS)) begin
      eff_rows = ERW'(MAX_ROWS);
    end else begin
      eff_rows = rows_ext;
    end
  end

  assign last_col = CW'(eff_cols - ECW'(1));
  assign last_row = RW'(eff_rows - ERW'(1));
  assign lastc_s  = $signed(CMPW'(last_col));
  assign lastr_s  = $signed(CMPW'(last_row));

  // floor of the coordinate and its successor
  assign ix0 = CMPW'(sample_x_i >>> FRAC_BITS);
  assign iy0 = CMPW'(sample_y_i >>> FRAC_BITS);
  assign ix1 = ix0 + CMPW'(1);
  assign iy1 = iy0 + CMPW'(1);

  always_comb begin
    if (ix0 < 0) begin
      x0 = '0;
    end else if (ix0 > lastc_s) begin
      x0 = last_col;
    end else begin
      x0 = ix0[CW-1:0];
    end
    if (ix1 < 0) begin
      x1 = '0;
    end else if (ix1 > lastc_s) begin
      x1 = last_col;
    end else begin
      x1 = ix1[CW-1:0];
    end
    if (iy0 < 0) begin
      y0 = '0;
    end else if (iy0 > lastr_s) begin
      y0 = last_row;
    end else begin
      y0 = iy0[RW-1:0];
    end
    if (iy1 < 0) begin
      y1 = '0;
    end else if (iy1 > lastr_s) begin
      y1 = last_row;
    end else begin
      y1 = iy1[RW-1:0];
    end
  end

  // each parity bank sees one of the two indices, equal ones when clamped together
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      col_half[p] = (x0[0] == p[0]) ? CHW'(x0 >> 1) : CHW'(x1 >> 1);
      row_half[p] = (y0[0] == p[0]) ? RHW'(y0 >> 1) : RHW'(y1 >> 1);
    end
    for (int b = 0; b < 4; b++) begin
      rd_addr_o[b] = {row_half[b/2], col_half[b%2]};
    end
  end

  assign rd_sel_o.x0_odd = x0[0];
  assign rd_sel_o.x1_odd = x1[0];
  assign rd_sel_o.y0_odd = y0[0];
  assign rd_sel_o.y1_odd = y1[0];
  assign rd_en_o = xfer_i && (operation_i == bis_pkg::OP_SAMPLE);

  assign wcol      = CW'(write_col_i);
  assign wrow      = RW'(write_row_i);
  assign wr_en_o   = xfer_i && (operation_i == bis_pkg::OP_WRITE)
                     && (ECW'(write_col_i) < eff_cols) && (ERW'(write_row_i) < eff_rows);
  assign wr_bank_o = {wrow[0], wcol[0]};
  assign wr_addr_o = {RHW'(wrow >> 1), CHW'(wcol >> 1)};

endmodule

### hdl/bis_pixel_banks.sv
// four parity banks of pixel memory with registered read data
module bis_pixel_banks #(
  parameter int unsigned AW = 14
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  wr_en_i,
  input  logic [1:0]                            wr_bank_i,
  input  logic [AW-1:0]                         wr_addr_i,
  input  logic [bis_pkg::PIX_W-1:0]             wr_data_i,
  input  logic                                  rd_en_i,
  input  logic [3:0][AW-1:0]                    rd_addr_i,
  input  bis_pkg::corner_sel_t                  rd_sel_i,
  output logic [3:0][bis_pkg::PIX_W-1:0]        rd_data_o,
  output bis_pkg::corner_sel_t                  rd_sel_o
);

  localparam int unsigned DEPTH = 2 ** AW;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [bis_pkg::PIX_W-1:0] mem [DEPTH];
    logic [bis_pkg::PIX_W-1:0] rdata_q;

    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_bank_i == 2'(b))) begin
        mem[wr_addr_i] <= wr_data_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rd_en_i) begin
        rdata_q <= mem[rd_addr_i[b]];
      end
    end

    assign rd_data_o[b] = rdata_q;
  end

  bis_pkg::corner_sel_t sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
    end else if (rd_en_i) begin
      sel_q <= rd_sel_i;
    end
  end

  assign rd_sel_o = sel_q;

endmodule

### hdl/bis_blend.sv
// two-stage bilinear blend: horizontal lerps, then vertical lerp with truncation
module bis_blend #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              rd_en_i,
  input  logic [FRAC_BITS-1:0]              frac_x_i,
  input  logic [FRAC_BITS-1:0]              frac_y_i,
  input  logic [3:0][bis_pkg::PIX_W-1:0]    rd_data_i,
  input  bis_pkg::corner_sel_t              rd_sel_i,
  output logic                              out_valid_o,
  output logic [bis_pkg::OUT_W-1:0]         out_value_o
);

  localparam int unsigned TW = bis_pkg::PIX_W + FRAC_BITS;
  localparam int unsigned LW = bis_pkg::PIX_W + FRAC_BITS + 3;
  localparam int unsigned SW = TW + FRAC_BITS + 3;
  localparam int unsigned RW = (TW > bis_pkg::OUT_W) ? TW : bis_pkg::OUT_W + 1;

  logic                 v1_q, v2_q, out_valid_q;
  logic [FRAC_BITS-1:0] a1_q, b1_q, b2_q;
  logic [TW-1:0]        top_q, bot_q;
  logic [bis_pkg::OUT_W-1:0] out_value_q;

  logic [bis_pkg::PIX_W-1:0] f0, f1, f2, f3;
  logic signed [LW-1:0] aw, top_s, bot_s;
  logic signed [SW-1:0] bw, top_w, bot_w, sum_s;
  logic [RW-1:0]        res;
  logic [bis_pkg::OUT_W-1:0] out_value_d;

  assign f0 = rd_data_i[{rd_sel_i.y0_odd, rd_sel_i.x0_odd}];
  assign f1 = rd_data_i[{rd_sel_i.y0_odd, rd_sel_i.x1_odd}];
  assign f2 = rd_data_i[{rd_sel_i.y1_odd, rd_sel_i.x0_odd}];
  assign f3 = rd_data_i[{rd_sel_i.y1_odd, rd_sel_i.x1_odd}];

  // f0 * S + (f1 - f0) * a
  assign aw    = $signed(LW'(a1_q));
  assign top_s = ($signed(LW'(f0)) <<< FRAC_BITS)
                 + ($signed(LW'(f1)) - $signed(LW'(f0))) * aw;
  assign bot_s = ($signed(LW'(f2)) <<< FRAC_BITS)
                 + ($signed(LW'(f3)) - $signed(LW'(f2))) * aw;

  // top * S + (bot - top) * b, then drop the fraction bits
  assign bw    = $signed(SW'(b2_q));
  assign top_w = $signed(SW'(top_q));
  assign bot_w = $signed(SW'(bot_q));
  assign sum_s = (top_w <<< FRAC_BITS) + (bot_w - top_w) * bw;
  assign res   = RW'(sum_s[TW+FRAC_BITS-1:FRAC_BITS]);

  always_comb begin
    if (res > RW'(bis_pkg::OUT_MAX)) begin
      out_value_d = bis_pkg::OUT_MAX;
    end else begin
      out_value_d = res[bis_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      v1_q        <= rd_en_i;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      a1_q <= frac_x_i;
      b1_q <= frac_y_i;
    end
    if (en_i && v1_q) begin
      top_q <= top_s[TW-1:0];
      bot_q <= bot_s[TW-1:0];
      b2_q  <= b1_q;
    end
    if (en_i && v2_q) begin
      out_value_q <= out_value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;

endmodule

### hdl/bilinear_image_sampler.sv
// top level of the bilinear image sampler with clamp-to-edge addressing
// Usage:
//   The input channel carries one item per transfer (in_valid_i high, in_stall_o low).
//   A write item stores write_value_i at (write_row_i, write_col_i) if it lies inside
//   image_cols x image_rows, and gives no result. A sample item gives one sample_value_o.
//   Sample coordinates are signed fixed point with FRAC_BITS fraction bits; the four
//   neighbours clamp to the image edges. Samples must only touch pixels written before.
//   Throughput is one item per clock while the receiver does not stall: the pixel store
//   is split into four banks by row and column parity, so the four corners are read in
//   the same cycle, one port per bank. A sample result passes through the bank read,
//   the horizontal blend and the vertical blend into the output register. A write is
//   visible to a sample transferred in the next cycle.
//   When the receiver stalls with a result waiting, the whole pipeline holds and
//   in_stall_o rises in the same cycle; no result is lost or repeated.
//   The config port writes image_cols (index 0) and image_rows (index 1) when cfg_we_i
//   is high; write it only while the pipeline is empty.
//   Reset sets both sizes to 256 and empties the pipeline; pixel memory is not cleared.
module bilinear_image_sampler #(
  parameter int unsigned MAX_COLS  = 256,
  parameter int unsigned MAX_ROWS  = 256,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bis_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bis_pkg::SIZE_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic [7:0]                          write_col_i,
  input  logic [7:0]                          write_row_i,
  input  logic [7:0]                          write_value_i,
  input  logic signed [bis_pkg::COORD_W-1:0]  sample_x_i,
  input  logic signed [bis_pkg::COORD_W-1:0]  sample_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bis_pkg::OUT_W-1:0]           sample_value_o
);

  localparam int unsigned CW  = $clog2(MAX_COLS);
  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned CHW = (CW > 1) ? CW - 1 : 1;
  localparam int unsigned RHW = (RW > 1) ? RW - 1 : 1;
  localparam int unsigned AW  = CHW + RHW;

  logic [bis_pkg::SIZE_W-1:0] image_cols_q, image_rows_q;
  logic en, xfer;
  logic wr_en, rd_en;
  logic [1:0] wr_bank;
  logic [AW-1:0] wr_addr;
  logic [3:0][AW-1:0] rd_addr;
  logic [3:0][bis_pkg::PIX_W-1:0] rd_data;
  bis_pkg::corner_sel_t rd_sel, rd_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_cols_q <= bis_pkg::SIZE_RESET;
      image_rows_q <= bis_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bis_pkg::CFG_IMAGE_COLS: image_cols_q <= cfg_wdata_i;
        bis_pkg::CFG_IMAGE_ROWS: image_rows_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a finished result is held by the receiver
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign xfer       = in_valid_i && en;

  bis_addr_gen #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .FRAC_BITS(FRAC_BITS),
    .CW       (CW),
    .RW       (RW),
    .CHW      (CHW),
    .RHW      (RHW)
  ) u_addr_gen (
    .xfer_i      (xfer),
    .operation_i (operation_i),
    .write_col_i (write_col_i),
    .write_row_i (write_row_i),
    .sample_x_i  (sample_x_i),
    .sample_y_i  (sample_y_i),
    .image_cols_i(image_cols_q),
    .image_rows_i(image_rows_q),
    .wr_en_o     (wr_en),
    .wr_bank_o   (wr_bank),
    .wr_addr_o   (wr_addr),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_sel_o    (rd_sel)
  );

  bis_pixel_banks #(
    .AW(AW)
  ) u_pixel_banks (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_bank_i(wr_bank),
    .wr_addr_i(wr_addr),
    .wr_data_i(write_value_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_sel_i (rd_sel),
    .rd_data_o(rd_data),
    .rd_sel_o (rd_sel_q)
  );

  bis_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .rd_en_i    (rd_en),
    .frac_x_i   (sample_x_i[FRAC_BITS-1:0]),
    .frac_y_i   (sample_y_i[FRAC_BITS-1:0]),
    .rd_data_i  (rd_data),
    .rd_sel_i   (rd_sel_q),
    .out_valid_o(out_valid_o),
    .out_value_o(sample_value_o)
  );

endmodule
